>>> src/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Types and constants shared by the isolated pixel removal unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ipr_pkg;

	localparam int unsigned SIZE_W = 6;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;  // input beat accepted: latch pixel, read history
		logic calc;  // update window, history and counters, load results
		logic pop;   // output beat accepted: retire the oldest pending result
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic has_out;   // the item in calculation produces at least one result
		logic one_left;  // at most one result is still pending
	} sts_t;

endpackage

`default_nettype wire

>>> src/ipr_pix_if.sv
// ----------------------------------------------------------------------------
// ipr_pix_if
// Input pixel channel: one pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_pix_if;
	logic valid;
	logic ready;
	logic pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> src/ipr_res_if.sv
// ----------------------------------------------------------------------------
// ipr_res_if
// Result channel: one filtered pixel per beat with its end markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_res_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic run_last;
	logic frame_last;

	modport source (output valid, output pixel_out, output run_last, output frame_last,
		input ready);
	modport sink (input valid, input pixel_out, input run_last, input frame_last,
		output ready);
endinterface

`default_nettype wire

>>> src/ipr_cfg_if.sv
// ----------------------------------------------------------------------------
// ipr_cfg_if
// Configuration write channel carrying the image size.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_cfg_if;
	logic valid;
	logic ready;
	logic [ipr_pkg::SIZE_W-1:0] image_size;

	modport source (output valid, output image_size, input ready);
	modport sink (input valid, input image_size, output ready);
endinterface

`default_nettype wire

>>> src/isolated_pixel_removal_unit.sv
// Latency: a pixel accepted at one edge is calculated in the next cycle; its
// first result beat is offered the cycle after that.
// A new pixel is taken only after the last is calculated and its results
// sent, due to the registered row history read and the single result port.
// Reset: size returns to 32, window and counters clear; history is not cleared.
`default_nettype none

module isolated_pixel_removal_unit #(
	parameter int unsigned MAX_SIZE = 32
) (
	input wire logic  clk,
	input wire logic  arst_n,
	ipr_pix_if.sink   pixels,
	ipr_res_if.source results,
	ipr_cfg_if.sink   cfg
);

	ipr_pkg::cmd_t cmd;
	ipr_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	ipr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixels.valid),
		.in_ready  (pixels.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ipr_dp #(
		.MAX_SIZE (MAX_SIZE)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_wr     (cfg.valid),
		.cfg_size   (cfg.image_size),
		.pixel_in   (pixels.pixel_in),
		.pixel_out  (results.pixel_out),
		.run_last   (results.run_last),
		.frame_last (results.frame_last)
	);

endmodule

`default_nettype wire

>>> src/ipr_ctrl.sv
// ----------------------------------------------------------------------------
// ipr_ctrl
// Controller: sequences accept, calculation and result delivery per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire ipr_pkg::sts_t sts,
	output ipr_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SEND
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take = in_ready_q && in_valid;
		cmd.calc = (state_q == ST_CALC);
		cmd.pop  = out_valid_q && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_ready_q && in_valid) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_CALC;
					end else begin
						in_ready_q <= 1'b1;
					end
				end
				ST_CALC: begin
					if (sts.has_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_SEND;
					end else begin
						in_ready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				ST_SEND: begin
					if (out_valid_q && out_ready && sts.one_left) begin
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					in_ready_q  <= 1'b0;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/ipr_dp.sv
// ----------------------------------------------------------------------------
// ipr_dp
// Datapath: row history memory, 3x3 window, position counters and results.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_dp #(
	parameter int unsigned MAX_SIZE = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ipr_pkg::cmd_t              cmd,
	output ipr_pkg::sts_t                   sts,
	input  wire logic                       cfg_wr,
	input  wire logic [ipr_pkg::SIZE_W-1:0] cfg_size,
	input  wire logic                       pixel_in,
	output logic                            pixel_out,
	output logic                            run_last,
	output logic                            frame_last
);

	localparam int unsigned AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int unsigned SW = ipr_pkg::SIZE_W;

	// Window bit index is column * 3 + row; cells beyond the window are unset.
	function automatic logic win_bit(input logic [8:0] w, input int r, input int c);
		if (r < 0 || r > 2 || c < 0 || c > 2) begin
			return 1'b0;
		end
		return w[c * 3 + r];
	endfunction

	function automatic logic filt(input logic [8:0] w, input int rc, input int cc);
		logic any;
		any = 1'b0;
		for (int r = rc - 1; r <= rc + 1; r++) begin
			for (int c = cc - 1; c <= cc + 1; c++) begin
				if (!(r == rc && c == cc)) begin
					any = any | win_bit(w, r, c);
				end
			end
		end
		return win_bit(w, rc, cc) & any;
	endfunction

	logic [SW-1:0] size_q;
	logic [SW-1:0] row_q;
	logic [SW-1:0] col_q;
	logic [8:0]    window_q;
	logic [3:0]    mask_q;
	logic [3:0]    bits_q;
	logic          pix_q;
	logic [1:0]    hist_q;
	logic [1:0]    hist_mem [MAX_SIZE];

	logic [SW-1:0] n;
	logic [SW-1:0] nm1;
	logic          wrap;
	logic [SW-1:0] row_e;
	logic [SW-1:0] col_e;
	logic [AW-1:0] addr;
	logic [8:0]    w_base;
	logic [2:0]    newcol;
	logic [8:0]    w;
	logic [3:0]    mask_d;
	logic [3:0]    bits_d;
	logic [SW-1:0] col_inc;
	logic [SW-1:0] row_inc;
	logic [3:0]    mask_rest;

	always_comb begin
		if (size_q == '0) begin
			n = SW'(1);
		end else if (size_q > SW'(MAX_SIZE)) begin
			n = SW'(MAX_SIZE);
		end else begin
			n = size_q;
		end
		nm1 = n - SW'(1);

		wrap  = (row_q >= n) || (col_q >= n);
		row_e = wrap ? '0 : row_q;
		col_e = wrap ? '0 : col_q;
		addr  = col_e[AW-1:0];

		w_base = (col_e == '0) ? '0 : window_q;
		newcol = {hist_q[0] & 1'b0, 2'b00};
		newcol[2] = pix_q;
		newcol[1] = (row_e != '0) ? hist_q[0] : 1'b0;
		newcol[0] = (row_e > SW'(1)) ? hist_q[1] : 1'b0;
		w = {newcol, w_base[8:3]};

		mask_d[0] = (row_e != '0) && (col_e != '0);
		mask_d[1] = (row_e != '0) && (col_e == nm1);
		mask_d[2] = (row_e == nm1) && (col_e != '0);
		mask_d[3] = (row_e == nm1) && (col_e == nm1);
		bits_d[0] = filt(w, 1, 1);
		bits_d[1] = filt(w, 1, 2);
		bits_d[2] = filt(w, 2, 1);
		bits_d[3] = filt(w, 2, 2);

		col_inc = col_e + SW'(1);
		row_inc = row_e + SW'(1);

		// Clearing the lowest set bit retires the result now on the port.
		mask_rest = mask_q & (mask_q - 4'd1);
	end

	assign sts.has_out  = |mask_d;
	assign sts.one_left = (mask_rest == 4'd0);

	always_comb begin
		pixel_out  = bits_q[3];
		frame_last = 1'b1;
		if (mask_q[0]) begin
			pixel_out  = bits_q[0];
			frame_last = 1'b0;
		end else if (mask_q[1]) begin
			pixel_out  = bits_q[1];
			frame_last = 1'b0;
		end else if (mask_q[2]) begin
			pixel_out  = bits_q[2];
			frame_last = 1'b0;
		end
		run_last = (mask_rest == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= ipr_pkg::SIZE_RESET;
			row_q    <= '0;
			col_q    <= '0;
			window_q <= '0;
			mask_q   <= '0;
		end else if (cfg_wr) begin
			size_q   <= cfg_size;
			row_q    <= '0;
			col_q    <= '0;
			window_q <= '0;
		end else if (cmd.calc) begin
			window_q <= w;
			mask_q   <= mask_d;
			if (col_inc >= n) begin
				col_q <= '0;
				row_q <= (row_inc >= n) ? '0 : row_inc;
			end else begin
				col_q <= col_inc;
				row_q <= row_e;
			end
		end else if (cmd.pop) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pix_q  <= pixel_in;
			hist_q <= hist_mem[addr];
		end
		if (cmd.calc) begin
			bits_q <= bits_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			hist_mem[addr] <= {hist_q[0], pix_q};
		end
	end

endmodule

`default_nettype wire
